// ===== design/prt_pkg.sv =====
// Shared types and constants for the point rigid transform block.
// No dependencies; every other design file imports this package.
package prt_pkg;

  localparam int COEF_FRAC_BITS = 14;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SUM_W   = ACC_W - COEF_FRAC_BITS;
  localparam int RES_W   = SUM_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3 * COEF_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // Reset values of the rotation rows: unity weight on x for output x, a
  // quarter on y for output y and a sixteenth on z for output z.
  localparam logic [CFG_DATA_W-1:0] ROT_X_RESET = 48'h0000_0000_4000;
  localparam logic [CFG_DATA_W-1:0] ROT_Y_RESET = 48'h0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] ROT_Z_RESET = 48'h0400_0000_0000;

  // Point class codes.
  localparam logic [1:0] CLS_NORMAL    = 2'd0;
  localparam logic [1:0] CLS_MAX_RANGE = 2'd1;
  localparam logic [1:0] CLS_INVALID   = 2'd2;

  // One output row: three coefficients, lane 0 weighs x, lane 2 weighs z.
  typedef struct packed {
    logic [2:0][COEF_W-1:0] coef;
    logic [COORD_W-1:0]     shift;
  } row_cfg_t;

  // Load strobes for the arithmetic stages inside each row unit.
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

endpackage

// ===== design/prt_cfg.sv =====
// Configuration register file for the point rigid transform block.
// Depends on prt_pkg for register indexes, reset values and row_cfg_t.
module prt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0] cfg_data,
  output prt_pkg::row_cfg_t              row_x,
  output prt_pkg::row_cfg_t              row_y,
  output prt_pkg::row_cfg_t              row_z
);
  import prt_pkg::*;

  logic [CFG_DATA_W-1:0] rot_x_r, rot_y_r, rot_z_r;
  logic [COORD_W-1:0]    shift_x_r, shift_y_r, shift_z_r;

  // Writes are always taken: cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r   <= ROT_X_RESET;
      rot_y_r   <= ROT_Y_RESET;
      rot_z_r   <= ROT_Z_RESET;
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROT_X:   rot_x_r   <= cfg_data;
        REG_ROT_Y:   rot_y_r   <= cfg_data;
        REG_ROT_Z:   rot_z_r   <= cfg_data;
        REG_SHIFT_X: shift_x_r <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Y: shift_y_r <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Z: shift_z_r <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign row_x = '{coef: rot_x_r, shift: shift_x_r};
  assign row_y = '{coef: rot_y_r, shift: shift_y_r};
  assign row_z = '{coef: rot_z_r, shift: shift_z_r};

endmodule

// ===== design/prt_row.sv =====
// One output coordinate: three products, rounded sum plus translation, saturation.
// Depends on prt_pkg for widths, row_cfg_t and pipe_ctl_t.
module prt_row (
  input  logic                             clk,
  input  prt_pkg::pipe_ctl_t               ctl,
  input  prt_pkg::row_cfg_t                cfg,
  input  logic signed [prt_pkg::COORD_W-1:0] op_x,
  input  logic signed [prt_pkg::COORD_W-1:0] op_y,
  input  logic signed [prt_pkg::COORD_W-1:0] op_z,
  output logic signed [prt_pkg::COORD_W-1:0] res
);
  import prt_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic signed [COEF_W-1:0]  c0, c1, c2;
  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0]  p0_nxt, p1_nxt, p2_nxt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [SUM_W-1:0]   rounded;
  logic signed [RES_W-1:0]   sum_r, sum_nxt;
  logic                      in_range;

  assign c0 = cfg.coef[0];
  assign c1 = cfg.coef[1];
  assign c2 = cfg.coef[2];

  assign p0_nxt = PROD_W'(c0) * PROD_W'(op_x);
  assign p1_nxt = PROD_W'(c1) * PROD_W'(op_y);
  assign p2_nxt = PROD_W'(c2) * PROD_W'(op_z);

  // Round to nearest with ties upward: add half an LSB, then floor.
  assign acc     = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r) + ROUND_BIAS;
  assign rounded = $signed(acc[ACC_W-1:COEF_FRAC_BITS]);
  assign sum_nxt = RES_W'(rounded) + RES_W'($signed(cfg.shift));

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (ctl.s2_load) begin
      sum_r <= sum_nxt;
    end
  end

  // The value fits when all bits above the result's sign bit agree with it.
  assign in_range = (&sum_r[RES_W-1:COORD_W-1]) || !(|sum_r[RES_W-1:COORD_W-1]);

  always_comb begin
    priority if (in_range) begin
      res = sum_r[COORD_W-1:0];
    end else if (sum_r[RES_W-1]) begin
      res = SAT_MIN;
    end else begin
      res = SAT_MAX;
    end
  end

endmodule

// ===== design/point_rigid_transform_max_range.sv =====
// Top level of the point rigid transform block with max-range handling.
// Depends on prt_pkg, prt_cfg and prt_row.
//
// Usage
// -----
// The input channel carries one depth point per beat (x, y, z, a finite flag,
// a range value and a range-present flag). The result channel returns one beat
// per input beat, in order: the rigidly transformed point, the x-valid flag,
// the range output and the point class. The configuration channel writes the
// three rotation rows (Q2.14 coefficients) and the three translations (Q16.16)
// by register index; it is always ready and should only be used while the
// block holds no point in flight.
//
// The datapath is a four-register pipeline: input register, product register,
// rounded-sum register and output register, which each beat passes in that
// order. While the receiver keeps out_ready high, one beat per cycle is
// sustained, set by the single multiplier rank per row. Each stage holds its
// beat while the stage after it is full and not draining, so when the receiver
// stalls the pipeline fills up and in_ready falls once all four stages are
// occupied; nothing is lost or repeated. Synchronous reset empties every stage
// and loads the reset rotation (unity weight on x for output x, a quarter on y
// for output y, a sixteenth on z for output z) with zero translation.
module point_rigid_transform_max_range (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [prt_pkg::COORD_W-1:0]    in_coord_x,
  input  logic signed [prt_pkg::COORD_W-1:0]    in_coord_y,
  input  logic signed [prt_pkg::COORD_W-1:0]    in_coord_z,
  input  logic                                  in_coords_finite,
  input  logic signed [prt_pkg::COORD_W-1:0]    in_range_in,
  input  logic                                  in_range_present,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [prt_pkg::COORD_W-1:0]    out_x,
  output logic signed [prt_pkg::COORD_W-1:0]    out_y,
  output logic signed [prt_pkg::COORD_W-1:0]    out_z,
  output logic                                  out_x_valid,
  output logic signed [prt_pkg::COORD_W-1:0]    out_range,
  output logic [1:0]                            out_point_class,
  // Configuration channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [prt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import prt_pkg::*;

  row_cfg_t  row_x_cfg, row_y_cfg, row_z_cfg;
  pipe_ctl_t ctl;

  // Stage occupancy.
  logic v0_r, v1_r, v2_r, v3_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic rdy1, rdy2, rdy3;
  logic load0, load1, load2, load3;

  // Stage 0: captured input beat.
  logic signed [COORD_W-1:0] x0_r, y0_r, z0_r, rng0_r;
  logic                      fin0_r, rp0_r;
  logic signed [COORD_W-1:0] op_x0;
  logic [1:0]                cls0;

  // Side band travelling alongside the arithmetic in stages 1 and 2.
  logic signed [COORD_W-1:0] x1_r, y1_r, z1_r, rng1_r;
  logic signed [COORD_W-1:0] x2_r, y2_r, z2_r, rng2_r;
  logic [1:0]                cls1_r, cls2_r;

  // Row results, valid while stage 2 is occupied.
  logic signed [COORD_W-1:0] res_x, res_y, res_z;

  // Stage 3: output register.
  logic signed [COORD_W-1:0] ox_r, oy_r, oz_r, orng_r;
  logic signed [COORD_W-1:0] ox_nxt, oy_nxt, oz_nxt, orng_nxt;
  logic                      oxv_r, oxv_nxt;
  logic [1:0]                ocls_r;

  prt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_x     (row_x_cfg),
    .row_y     (row_y_cfg),
    .row_z     (row_z_cfg)
  );

  // Handshake chain: a stage can take a beat when it is empty or its beat moves on.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;

  assign load0 = in_valid && in_ready;
  assign load1 = v0_r && rdy1;
  assign load2 = v1_r && rdy2;
  assign load3 = v2_r && rdy3;

  assign v0_nxt = load0 || (v0_r && !rdy1);
  assign v1_nxt = load1 || (v1_r && !rdy2);
  assign v2_nxt = load2 || (v2_r && !rdy3);
  assign v3_nxt = load3 || (v3_r && !out_ready);

  assign ctl = '{s1_load: load1, s2_load: load2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // A point without finite coordinates but with a range is a max-range point:
  // the range stands in for x through the transform.
  always_comb begin
    priority if (fin0_r) begin
      cls0 = CLS_NORMAL;
    end else if (rp0_r) begin
      cls0 = CLS_MAX_RANGE;
    end else begin
      cls0 = CLS_INVALID;
    end
  end

  assign op_x0 = (cls0 == CLS_MAX_RANGE) ? rng0_r : x0_r;

  always_ff @(posedge clk) begin
    if (load0) begin
      x0_r   <= in_coord_x;
      y0_r   <= in_coord_y;
      z0_r   <= in_coord_z;
      rng0_r <= in_range_in;
      fin0_r <= in_coords_finite;
      rp0_r  <= in_range_present;
    end
    if (load1) begin
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      z1_r   <= z0_r;
      rng1_r <= rng0_r;
      cls1_r <= cls0;
    end
    if (load2) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      z2_r   <= z1_r;
      rng2_r <= rng1_r;
      cls2_r <= cls1_r;
    end
  end

  prt_row u_row_x (
    .clk  (clk),
    .ctl  (ctl),
    .cfg  (row_x_cfg),
    .op_x (op_x0),
    .op_y (y0_r),
    .op_z (z0_r),
    .res  (res_x)
  );

  prt_row u_row_y (
    .clk  (clk),
    .ctl  (ctl),
    .cfg  (row_y_cfg),
    .op_x (op_x0),
    .op_y (y0_r),
    .op_z (z0_r),
    .res  (res_y)
  );

  prt_row u_row_z (
    .clk  (clk),
    .ctl  (ctl),
    .cfg  (row_z_cfg),
    .op_x (op_x0),
    .op_y (y0_r),
    .op_z (z0_r),
    .res  (res_z)
  );

  // Output selection. For a max-range point the transformed x leaves on the
  // range field and x itself is zeroed and flagged invalid. An invalid point
  // without a range passes through untouched.
  always_comb begin
    unique case (cls2_r)
      CLS_NORMAL: begin
        ox_nxt   = res_x;
        oy_nxt   = res_y;
        oz_nxt   = res_z;
        orng_nxt = rng2_r;
        oxv_nxt  = 1'b1;
      end
      CLS_MAX_RANGE: begin
        ox_nxt   = '0;
        oy_nxt   = res_y;
        oz_nxt   = res_z;
        orng_nxt = res_x;
        oxv_nxt  = 1'b0;
      end
      default: begin
        ox_nxt   = x2_r;
        oy_nxt   = y2_r;
        oz_nxt   = z2_r;
        orng_nxt = rng2_r;
        oxv_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      oz_r   <= oz_nxt;
      orng_r <= orng_nxt;
      oxv_r  <= oxv_nxt;
      ocls_r <= cls2_r;
    end
  end

  assign out_valid       = v3_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_range       = orng_r;
  assign out_x_valid     = oxv_r;
  assign out_point_class = ocls_r;

  // A max-range result never carries a valid x, and it is zeroed.
  a_max_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_point_class == CLS_MAX_RANGE) |-> (!out_x_valid && out_x == '0))
    else $error("max-range result carries an x coordinate");

  // Only normal points report a valid x.
  a_xvalid_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_valid == (out_point_class == CLS_NORMAL)))
    else $error("x-valid flag disagrees with point class");

  // With every stage full and the receiver stalled, no new beat may enter.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline is full and stalled");

  // A stalled output beat stays in place on the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_ready) |=> (v3_r && $stable(ox_r) && $stable(orng_r)))
    else $error("stalled output register changed");

  // An accepted input beat always occupies the first stage next cycle.
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v0_r)
    else $error("accepted beat not captured");

endmodule

// ===== sim/point_rigid_transform_max_range_test.sv =====
// Self-checking testbench for point_rigid_transform_max_range: a directed table of
// points, then random points under several transforms, all checked beat by beat.
// Depends on prt_pkg and the design files under design/.
module point_rigid_transform_max_range_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prt_pkg::*;

  // Run shape. The quiet limit is many times the longest gap a correct run can
  // show: the deliberate hold-off on the result side plus random stalls.
  localparam int QUIET_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES  = 64;
  localparam int PRESSURE_POINTS  = 24;
  localparam int PHASES           = 8;
  localparam int POINTS_PER_PHASE = 70;
  localparam int SETTLE_CYCLES    = 8;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] SETTING_REGS [6] = '{REG_ROT_X, REG_ROT_Y, REG_ROT_Z,
                                                          REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z};

  localparam longint SAT_HI = 64'sh7fff_ffff;
  localparam longint SAT_LO = -SAT_HI - 1;

  // One point as offered on the input channel.
  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      coords_finite;
    logic signed [COORD_W-1:0] range_in;
    logic                      range_present;
  } point_t;

  // One transformed point as returned on the result channel.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      x_valid;
    logic signed [COORD_W-1:0] range_out;
    logic [1:0]                point_class;
  } result_t;

  // A row of the directed table: the point, and the result when it is typed in.
  typedef struct {
    point_t  pt;
    logic    typed;
    result_t want;
  } vector_t;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_ready;
  logic signed [31:0]     in_coord_x       = '0;
  logic signed [31:0]     in_coord_y       = '0;
  logic signed [31:0]     in_coord_z       = '0;
  logic                   in_coords_finite = 1'b0;
  logic signed [31:0]     in_range_in      = '0;
  logic                   in_range_present = 1'b0;
  logic                   out_valid;
  logic                   out_ready        = 1'b0;
  logic signed [31:0]     out_x;
  logic signed [31:0]     out_y;
  logic signed [31:0]     out_z;
  logic                   out_x_valid;
  logic signed [31:0]     out_range;
  logic [1:0]             out_point_class;
  logic                   cfg_valid        = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index        = '0;
  logic [CFG_DATA_W-1:0]  cfg_data         = '0;

  // Our own copy of the transform, updated as each register write is taken.
  row_cfg_t  xform_rows [3];
  result_t   pending_transforms [$];

  int        mismatches     = 0;
  int        results_seen   = 0;
  int        quiet_cycles   = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  logic      gapless        = 1'b0;
  logic      hold_pending   = 1'b0;

  point_rigid_transform_max_range u_dut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One output coordinate: the exact dot product, rounded to nearest with ties
  // going upwards as the coefficient fraction is dropped, then the shift added
  // and the sum clamped to the 32-bit range.
  function automatic logic signed [COORD_W-1:0] apply_row(input row_cfg_t row,
      input logic signed [COORD_W-1:0] px, py, pz);
    longint acc;
    acc = longint'($signed(row.coef[0])) * longint'(px)
        + longint'($signed(row.coef[1])) * longint'(py)
        + longint'($signed(row.coef[2])) * longint'(pz);
    acc = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    acc = acc + longint'($signed(row.shift));
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[COORD_W-1:0];
  endfunction

  // Works out the whole result beat for one point. A point with a usable
  // range but no usable coordinates is a max-range point: the range stands in
  // for x, and the transformed x leaves on the range output instead.
  function automatic result_t transform_point(input point_t p);
    result_t r;
    r.x           = p.coord_x;
    r.y           = p.coord_y;
    r.z           = p.coord_z;
    r.x_valid     = 1'b0;
    r.range_out   = p.range_in;
    r.point_class = CLS_INVALID;
    if (p.coords_finite) begin
      r.x           = apply_row(xform_rows[0], p.coord_x, p.coord_y, p.coord_z);
      r.y           = apply_row(xform_rows[1], p.coord_x, p.coord_y, p.coord_z);
      r.z           = apply_row(xform_rows[2], p.coord_x, p.coord_y, p.coord_z);
      r.x_valid     = 1'b1;
      r.point_class = CLS_NORMAL;
    end else if (p.range_present) begin
      r.range_out   = apply_row(xform_rows[0], p.range_in, p.coord_y, p.coord_z);
      r.y           = apply_row(xform_rows[1], p.range_in, p.coord_y, p.coord_z);
      r.z           = apply_row(xform_rows[2], p.range_in, p.coord_y, p.coord_z);
      r.x           = '0;
      r.point_class = CLS_MAX_RANGE;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic point_t point_of(input logic signed [31:0] px, py, pz,
      input logic finite, input logic signed [31:0] rng, input logic present);
    point_t p;
    p = '{px, py, pz, finite, rng, present};
    return p;
  endfunction

  function automatic result_t result_of(input logic signed [31:0] rx, ry, rz,
      input logic xv, input logic signed [31:0] rng, input logic [1:0] cls);
    result_t r;
    r = '{rx, ry, rz, xv, rng, cls};
    return r;
  endfunction

  // Coordinates lean towards the two extremes and towards values within a
  // few metres of the origin, where rounding matters more than saturation.
  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return 32'(int'($urandom_range(32'h0020_0000)) - 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  // Roughly six points in ten are normal, two are max-range, two are invalid.
  function automatic point_t random_point();
    point_t p;
    int unsigned kind;
    kind            = $urandom_range(9);
    p.coord_x       = random_coord();
    p.coord_y       = random_coord();
    p.coord_z       = random_coord();
    p.range_in      = random_coord();
    p.coords_finite = kind < 6;
    p.range_present = (kind < 6) ? 1'($urandom) : (kind < 8);
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR: result beat %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // Drops valid for a random number of cycles, unless the run wants a
  // continuous stream just now.
  task automatic idle_sender();
    while (!gapless && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Offers one point and holds it until the block takes it. The expectation
  // is queued at the edge of acceptance, so config can never slip in between.
  task automatic offer_point(input point_t p, input logic typed, input result_t want);
    in_valid         <= 1'b1;
    in_coord_x       <= p.coord_x;
    in_coord_y       <= p.coord_y;
    in_coord_z       <= p.coord_z;
    in_coords_finite <= p.coords_finite;
    in_range_in      <= p.range_in;
    in_range_present <= p.range_present;
    do @(posedge clk); while (!in_ready);
    pending_transforms.push_back(typed ? want : transform_point(p));
  endtask

  // Stops offering and waits for every outstanding result beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_transforms.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROT_X:   xform_rows[0].coef  = value;
      REG_ROT_Y:   xform_rows[1].coef  = value;
      REG_ROT_Z:   xform_rows[2].coef  = value;
      REG_SHIFT_X: xform_rows[0].shift = value[COORD_W-1:0];
      REG_SHIFT_Y: xform_rows[1].shift = value[COORD_W-1:0];
      REG_SHIFT_Z: xform_rows[2].shift = value[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // Loads a complete transform for one phase. Shift writes always carry
  // random bits above the 32-bit field, which the block must ignore.
  task automatic apply_setting(input int phase);
    logic [CFG_DATA_W-1:0] value [6];
    int k;
    int lane;
    for (k = 0; k < 6; k++) begin
      value[k] = {16'($urandom), 32'($urandom)};
    end
    case (phase)
      1: begin
        // Largest positive coefficients and shift: drives results into the
        // upper clamp.
        for (k = 0; k < 3; k++) value[k] = 48'h7fff_7fff_7fff;
        for (k = 3; k < 6; k++) value[k][31:0] = 32'h7fff_ffff;
      end
      2: begin
        for (k = 0; k < 3; k++) value[k] = 48'h8000_8000_8000;
        for (k = 3; k < 6; k++) value[k][31:0] = 32'h8000_0000;
      end
      4: begin
        // Tiny coefficients with no shift, so that the rounding of half-way
        // sums shows directly in the low bits.
        for (k = 0; k < 3; k++) begin
          for (lane = 0; lane < 3; lane++) begin
            value[k][lane*COEF_W +: COEF_W] = 16'(int'($urandom_range(8)) - 4);
          end
        end
        for (k = 3; k < 6; k++) value[k][31:0] = '0;
      end
      5: begin
        for (k = 0; k < 3; k++) value[k] = '0;
      end
      7: begin
        // Quarter turn about z: x' = -y, y' = x, z' = z.
        value[0] = 48'h0000_c000_0000;
        value[1] = 48'h0000_0000_4000;
        value[2] = 48'h4000_0000_0000;
      end
      default: ;
    endcase
    for (k = 0; k < 6; k++) begin
      write_register(SETTING_REGS[k], value[k]);
    end
    if (phase == 6) begin
      write_register(REG_SPARE_LO, {16'($urandom), 32'($urandom)});
      write_register(REG_SPARE_HI, {16'($urandom), 32'($urandom)});
    end
    cfg_valid <= 1'b0;
  endtask

  // The sender idles often and the receiver more often in the first third,
  // then the other way round, and in the last third neither idles.
  task automatic set_idling(input int phase);
    if (phase <= 2) begin
      send_idle_pct = 28;
      recv_idle_pct = 51;
    end else if (phase <= 5) begin
      send_idle_pct = 51;
      recv_idle_pct = 28;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, with one long hold-off on request.
  // The hold-off is counted here so that the sender keeps offering points
  // meanwhile and the pipeline fills until it refuses input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Every result beat taken is compared field by field with the oldest
  // expectation still waiting.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_transforms.size() == 0) begin
        report_mismatch($sformatf("beat with no point outstanding (x %h y %h z %h)",
                                  out_x, out_y, out_z));
      end else begin
        want = pending_transforms.pop_front();
        if (out_x !== want.x)
          report_mismatch($sformatf("out_x %h, expected %h", out_x, want.x));
        if (out_y !== want.y)
          report_mismatch($sformatf("out_y %h, expected %h", out_y, want.y));
        if (out_z !== want.z)
          report_mismatch($sformatf("out_z %h, expected %h", out_z, want.z));
        if (out_x_valid !== want.x_valid)
          report_mismatch($sformatf("out_x_valid %b, expected %b", out_x_valid, want.x_valid));
        if (out_range !== want.range_out)
          report_mismatch($sformatf("out_range %h, expected %h", out_range, want.range_out));
        if (out_point_class !== want.point_class)
          report_mismatch($sformatf("out_point_class %0d, expected %0d",
                                    out_point_class, want.point_class));
      end
    end
  end

  // Counts cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("point_rigid_transform_max_range test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    vector_t directed [$];
    int phase;
    int n;

    // After reset output x takes x at unity weight, output y takes a quarter
    // of y and output z a sixteenth of z, with no shift, so the directed rows
    // can mostly have their results typed in. Max-range points return the
    // range on the range output with x cleared, and invalid points pass
    // straight through.
    directed.push_back('{point_of(32'h0001_0000, 32'hfffe_0000, 32'h0003_0000, 1'b1, '0, 1'b0),
        1'b1, result_of(32'h0001_0000, 32'hffff_8000, 32'h0000_3000, 1'b1, '0, CLS_NORMAL)});
    directed.push_back('{point_of(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1,
        32'h7fff_ffff, 1'b1), 1'b1, result_of(32'h7fff_ffff, 32'h2000_0000, 32'h0800_0000,
        1'b1, 32'h7fff_ffff, CLS_NORMAL)});
    directed.push_back('{point_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
        32'h8000_0000, 1'b0), 1'b1, result_of(32'h8000_0000, 32'he000_0000, 32'hf800_0000,
        1'b1, 32'h8000_0000, CLS_NORMAL)});
    directed.push_back('{point_of('0, '0, '0, 1'b1, '0, 1'b0), 1'b1,
        result_of('0, '0, '0, 1'b1, '0, CLS_NORMAL)});
    // Smallest steps either side of zero: x keeps them exactly, while the
    // quarter weight on y rounds minus one LSB up to zero.
    directed.push_back('{point_of(32'h0000_0001, 32'hffff_ffff, 32'h1234_5678, 1'b1,
        32'h0000_0001, 1'b1), 1'b1, result_of(32'h0000_0001, 32'h0000_0000, 32'h0123_4568,
        1'b1, 32'h0000_0001, CLS_NORMAL)});
    directed.push_back('{point_of(32'h5555_5555, 32'h0001_0000, 32'hffff_0000, 1'b0,
        32'h000a_0000, 1'b1), 1'b1, result_of('0, 32'h0000_4000, 32'hffff_f000, 1'b0,
        32'h000a_0000, CLS_MAX_RANGE)});
    directed.push_back('{point_of('0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h7fff_ffff, 1'b1),
        1'b1, result_of('0, 32'he000_0000, 32'h0800_0000, 1'b0, 32'h7fff_ffff, CLS_MAX_RANGE)});
    directed.push_back('{point_of(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0,
        32'h8000_0000, 1'b1), 1'b1, result_of('0, 32'h2000_0000, 32'hf800_0000, 1'b0,
        32'h8000_0000, CLS_MAX_RANGE)});
    directed.push_back('{point_of(32'hdead_beef, 32'h1234_5678, 32'h8000_0000, 1'b0,
        32'hffff_ffff, 1'b0), 1'b1, result_of(32'hdead_beef, 32'h1234_5678, 32'h8000_0000,
        1'b0, 32'hffff_ffff, CLS_INVALID)});
    directed.push_back('{point_of(32'h7fff_ffff, 32'h8000_0000, '0, 1'b0, 32'h8000_0000, 1'b0),
        1'b1, result_of(32'h7fff_ffff, 32'h8000_0000, '0, 1'b0, 32'h8000_0000, CLS_INVALID)});
    // The remaining rows are left to the predictor.
    directed.push_back('{point_of(32'h0000_8000, 32'hffff_8000, 32'h7fff_0000, 1'b1,
        32'h0000_1234, 1'b0), 1'b0, '0});
    directed.push_back('{point_of(32'h0bad_f00d, 32'hfff0_8001, 32'h0000_7fff, 1'b0,
        32'hfffe_c001, 1'b1), 1'b0, '0});
    directed.push_back('{point_of(32'haaaa_aaaa, 32'h5555_5555, 32'hcccc_cccc, 1'b0,
        32'h3333_3333, 1'b0), 1'b0, '0});

    xform_rows[0] = '{coef: ROT_X_RESET, shift: '0};
    xform_rows[1] = '{coef: ROT_Y_RESET, shift: '0};
    xform_rows[2] = '{coef: ROT_Z_RESET, shift: '0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    foreach (directed[i]) begin
      idle_sender();
      offer_point(directed[i].pt, directed[i].typed, directed[i].want);
    end
    drain_results();

    // Each phase loads a transform while nothing is in flight, streams random
    // points through it, then waits for the last result before moving on.
    for (phase = 1; phase <= PHASES; phase++) begin
      set_idling(phase);
      apply_setting(phase);
      // In this phase the receiver holds off for a long stretch while the
      // first points go in back to back, so the block must fill and stall.
      if (phase == 3) hold_pending = 1'b1;
      for (n = 0; n < POINTS_PER_PHASE; n++) begin
        gapless = (phase == 3) && (n < PRESSURE_POINTS);
        idle_sender();
        offer_point(random_point(), 1'b0, '0);
      end
      drain_results();
    end

    // Wait out the settle period to catch any stray beat after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("point_rigid_transform_max_range test passed");
    end else begin
      $display("point_rigid_transform_max_range test failed");
    end
    $finish;
  end

endmodule
